>>> rtl/core/cds_pkg.sv
// shared types, widths and constants for the concentric disk sampler
// no dependencies; used by the prep, divider, cordic, scale and top modules by scoped names
package cds_pkg;

    localparam int IN_W   = 16;   // width of one uniform input
    localparam int OFS_W  = 17;   // signed offset 2u-1 scaled by 32768
    localparam int MAG_W  = 17;   // magnitude of an offset, up to 32768
    localparam int PROD_W = 46;   // pi/4 in q2.30 times a minor magnitude
    localparam int DIV_W  = 48;   // dividend and shifted divisor
    localparam int OUT_W  = 18;   // signed q1.16 coordinate
    localparam int OUT_MAX = 65536;

    localparam longint Q30_PI4  = 64'sd843314857;
    localparam longint Q30_GAIN = 64'sd652032874;

    localparam longint ATAN_Q30 [30] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
        64'sd33543516,  64'sd16775851,  64'sd8388437,   64'sd4194283,   64'sd2097149,
        64'sd1048576,   64'sd524288,    64'sd262144,    64'sd131072,    64'sd65536,
        64'sd32768,     64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128,       64'sd64,
        64'sd32,        64'sd16,        64'sd8,         64'sd4,         64'sd2
    };

    // sideband that travels with each item down the pipeline
    typedef struct packed {
        logic                    zero;
        logic                    on_x;
        logic                    neg;
        logic signed [OFS_W-1:0] major;
    } ctx_t;

    // q2.30 positive constant rounded to frac fraction bits, ties away from zero
    function automatic longint q30_round(input longint v, input int frac);
        int s;
        s = 30 - frac;
        return ((v <<< 1) + (64'sd1 <<< s)) >>> (s + 1);
    endfunction

endpackage

>>> rtl/core/cds_prep.sv
// front end: offsets, major/minor axis selection and pi/4 * |minor| product
// depends on cds_pkg
module cds_prep
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [cds_pkg::IN_W-1:0]     u_x,
    input  logic [cds_pkg::IN_W-1:0]     u_y,
    output logic                         out_valid,
    output logic [cds_pkg::PROD_W-1:0]   prod,
    output logic [cds_pkg::MAG_W-1:0]    mag_major,
    output cds_pkg::ctx_t                ctx
);

    logic signed [cds_pkg::OFS_W-1:0] a, b, major, minor;
    logic [cds_pkg::MAG_W-1:0] ma, mb;
    logic on_x;

    logic v1_reg, v2_reg;
    cds_pkg::ctx_t ctx1_reg, ctx2_reg;
    logic [cds_pkg::MAG_W-1:0] mmin_reg, mmaj1_reg, mmaj2_reg;
    logic [cds_pkg::PROD_W-1:0] prod_reg;
    logic [cds_pkg::PROD_W-1:0] prod_next;

    always_comb
    begin
        a     = $signed({1'b0, u_x}) - $signed(cds_pkg::OFS_W'(32768));
        b     = $signed({1'b0, u_y}) - $signed(cds_pkg::OFS_W'(32768));
        ma    = a[cds_pkg::OFS_W-1] ? cds_pkg::MAG_W'(-a) : cds_pkg::MAG_W'(a);
        mb    = b[cds_pkg::OFS_W-1] ? cds_pkg::MAG_W'(-b) : cds_pkg::MAG_W'(b);
        on_x  = ma > mb;
        major = on_x ? a : b;
        minor = on_x ? b : a;
        prod_next = cds_pkg::PROD_W'(cds_pkg::Q30_PI4[29:0]) * cds_pkg::PROD_W'(mmin_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx1_reg.zero  <= (a == '0) && (b == '0);
            ctx1_reg.on_x  <= on_x;
            ctx1_reg.neg   <= minor[cds_pkg::OFS_W-1] ^ major[cds_pkg::OFS_W-1];
            ctx1_reg.major <= major;
            mmin_reg       <= on_x ? mb : ma;
            mmaj1_reg      <= on_x ? ma : mb;
            ctx2_reg       <= ctx1_reg;
            mmaj2_reg      <= mmaj1_reg;
            prod_reg       <= prod_next;
        end
    end

    assign out_valid = v2_reg;
    assign prod      = prod_reg;
    assign mag_major = mmaj2_reg;
    assign ctx       = ctx2_reg;

endmodule

>>> rtl/core/cds_div.sv
// pipelined restoring divider, one quotient bit per stage: angle magnitude = pi/4 * |minor|/|major|
// depends on cds_pkg
module cds_div
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [cds_pkg::PROD_W-1:0]    prod,
    input  logic [cds_pkg::MAG_W-1:0]     mag_major,
    input  cds_pkg::ctx_t                 ctx_in,
    output logic                          out_valid,
    output logic [FRAC_BITS:0]            quo,
    output cds_pkg::ctx_t                 ctx_out
);

    localparam int SH = 30 - FRAC_BITS;
    localparam int QN = FRAC_BITS + 1;

    logic [cds_pkg::DIV_W-1:0] dvs, num0;

    logic [cds_pkg::DIV_W-1:0] rem_reg [QN];
    logic [cds_pkg::DIV_W-1:0] den_reg [QN];
    logic [QN-1:0]             q_reg   [QN];
    cds_pkg::ctx_t             ctx_reg [QN];
    logic [QN-1:0]             vld_reg;

    // round to nearest: floor((2n + d) / 2d)
    always_comb
    begin
        dvs  = cds_pkg::DIV_W'(mag_major) << SH;
        num0 = (cds_pkg::DIV_W'(prod) << 1) + dvs;
    end

    for (genvar k = 0; k < QN; k++)
    begin : g_stage
        localparam int BIT = QN - 1 - k;
        logic [cds_pkg::DIV_W-1:0] rin, din, trial;
        logic [QN-1:0] qin, q_next;
        cds_pkg::ctx_t cin;
        logic vin, ge;

        if (k == 0)
        begin : g_first
            assign rin = num0;
            assign din = dvs << 1;
            assign qin = '0;
            assign cin = ctx_in;
            assign vin = in_valid;
        end
        else
        begin : g_rest
            assign rin = rem_reg[k-1];
            assign din = den_reg[k-1];
            assign qin = q_reg[k-1];
            assign cin = ctx_reg[k-1];
            assign vin = vld_reg[k-1];
        end

        always_comb
        begin
            trial       = din << BIT;
            ge          = rin >= trial;
            q_next      = qin;
            q_next[BIT] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= ge ? rin - trial : rin;
                den_reg[k] <= din;
                q_reg[k]   <= q_next;
                ctx_reg[k] <= cin;
            end
        end
    end

    assign out_valid = vld_reg[QN-1];
    assign quo       = q_reg[QN-1];
    assign ctx_out   = ctx_reg[QN-1];

endmodule

>>> rtl/core/cds_cordic.sv
// rotation-mode cordic, one micro-rotation per register stage
// depends on cds_pkg
module cds_cordic
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [FRAC_BITS:0]            quo,
    input  cds_pkg::ctx_t                 ctx_in,
    output logic                          out_valid,
    output logic signed [FRAC_BITS+1:0]   cos_o,
    output logic signed [FRAC_BITS+1:0]   sin_o,
    output cds_pkg::ctx_t                 ctx_out
);

    localparam int VW = FRAC_BITS + 2;
    localparam logic signed [VW-1:0] X0 =
        VW'(cds_pkg::q30_round(cds_pkg::Q30_GAIN, FRAC_BITS));

    logic signed [VW-1:0] z0;

    logic signed [VW-1:0] x_reg [CORDIC_STEPS];
    logic signed [VW-1:0] y_reg [CORDIC_STEPS];
    logic signed [VW-1:0] z_reg [CORDIC_STEPS];
    cds_pkg::ctx_t        ctx_reg [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] vld_reg;

    assign z0 = ctx_in.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [VW-1:0] ANG =
            VW'(cds_pkg::q30_round(cds_pkg::ATAN_Q30[i], FRAC_BITS));
        logic signed [VW-1:0] xin, yin, zin, dx, dy;
        cds_pkg::ctx_t cin;
        logic vin;

        if (i == 0)
        begin : g_first
            assign xin = X0;
            assign yin = '0;
            assign zin = z0;
            assign cin = ctx_in;
            assign vin = in_valid;
        end
        else
        begin : g_rest
            assign xin = x_reg[i-1];
            assign yin = y_reg[i-1];
            assign zin = z_reg[i-1];
            assign cin = ctx_reg[i-1];
            assign vin = vld_reg[i-1];
        end

        // arithmetic shifts floor toward minus infinity
        assign dx = yin >>> i;
        assign dy = xin >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (adv)
                vld_reg[i] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!zin[VW-1])
                begin
                    x_reg[i] <= xin - dx;
                    y_reg[i] <= yin + dy;
                    z_reg[i] <= zin - ANG;
                end
                else
                begin
                    x_reg[i] <= xin + dx;
                    y_reg[i] <= yin - dy;
                    z_reg[i] <= zin + ANG;
                end
                ctx_reg[i] <= cin;
            end
        end
    end

    assign out_valid = vld_reg[CORDIC_STEPS-1];
    assign cos_o     = x_reg[CORDIC_STEPS-1];
    assign sin_o     = y_reg[CORDIC_STEPS-1];
    assign ctx_out   = ctx_reg[CORDIC_STEPS-1];

endmodule

>>> rtl/core/cds_scale.sv
// radius scaling, rounding, saturation and axis swap; last stage is the output register
// depends on cds_pkg
module cds_scale
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic signed [FRAC_BITS+1:0]       cos_i,
    input  logic signed [FRAC_BITS+1:0]       sin_i,
    input  cds_pkg::ctx_t                     ctx_in,
    output logic                              out_valid,
    output logic signed [cds_pkg::OUT_W-1:0]  disk_x,
    output logic signed [cds_pkg::OUT_W-1:0]  disk_y
);

    localparam int VW = FRAC_BITS + 2;
    localparam int PW = VW + cds_pkg::OFS_W;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 2);

    logic signed [PW-1:0] pc_reg, ps_reg;
    cds_pkg::ctx_t ctx_reg;
    logic va_reg, vb_reg;
    logic signed [cds_pkg::OUT_W-1:0] x_reg, y_reg;
    logic signed [cds_pkg::OUT_W-1:0] rc, rs;

    function automatic logic signed [cds_pkg::OUT_W-1:0] rnd_sat(
        input logic signed [PW-1:0] p);
        logic [PW-1:0] m, q;
        logic [cds_pkg::OUT_W-1:0] c;
        m = p[PW-1] ? PW'(-p) : PW'(p);
        q = (m + HALF) >> (FRAC_BITS - 1);
        c = (q > PW'(cds_pkg::OUT_MAX)) ? cds_pkg::OUT_W'(cds_pkg::OUT_MAX)
                                        : cds_pkg::OUT_W'(q);
        return p[PW-1] ? -$signed(c) : $signed(c);
    endfunction

    assign rc = rnd_sat(pc_reg);
    assign rs = rnd_sat(ps_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pc_reg  <= PW'(ctx_in.major) * PW'(cos_i);
            ps_reg  <= PW'(ctx_in.major) * PW'(sin_i);
            ctx_reg <= ctx_in;
            if (ctx_reg.zero)
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            else if (ctx_reg.on_x)
            begin
                x_reg <= rc;
                y_reg <= rs;
            end
            else
            begin
                x_reg <= rs;
                y_reg <= rc;
            end
        end
    end

    assign out_valid = vb_reg;
    assign disk_x    = x_reg;
    assign disk_y    = y_reg;

endmodule

>>> rtl/core/concentric_disk_sampler.sv
// top level of the concentric disk sampler: prep, divider, cordic and scale stages
// depends on cds_pkg, cds_prep, cds_div, cds_cordic, cds_scale
//
//  channel | direction | fields (lowest bit first)
//  s_axis  | in        | tdata: u_x[15:0], u_y[31:16]
//  m_axis  | out       | tdata: disk_x[17:0], disk_y[35:18], zero pad to 40 bits
//
// one transfer in and one out per cycle when the output is taken
// register stages: 2 prep, FRAC_BITS+1 divider
// stages (one quotient bit each), CORDIC_STEPS rotation stages, 2 scale stages
// every stage moves on the same enable; a stalled output freezes the whole pipe
// asynchronous active-low reset clears only the valid bits
module concentric_disk_sampler
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // u_x, u_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // disk_x, disk_y, pad
);

    logic adv;
    logic p_valid, d_valid, c_valid;
    logic [cds_pkg::PROD_W-1:0] prod;
    logic [cds_pkg::MAG_W-1:0] mag_major;
    logic [FRAC_BITS:0] quo;
    logic signed [FRAC_BITS+1:0] cos_v, sin_v;
    cds_pkg::ctx_t p_ctx, d_ctx, c_ctx;
    logic signed [cds_pkg::OUT_W-1:0] disk_x, disk_y;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    cds_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .u_x       (s_tdata[15:0]),
        .u_y       (s_tdata[31:16]),
        .out_valid (p_valid),
        .prod      (prod),
        .mag_major (mag_major),
        .ctx       (p_ctx)
    );

    cds_div #(.FRAC_BITS(FRAC_BITS)) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p_valid),
        .prod      (prod),
        .mag_major (mag_major),
        .ctx_in    (p_ctx),
        .out_valid (d_valid),
        .quo       (quo),
        .ctx_out   (d_ctx)
    );

    cds_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_valid),
        .quo       (quo),
        .ctx_in    (d_ctx),
        .out_valid (c_valid),
        .cos_o     (cos_v),
        .sin_o     (sin_v),
        .ctx_out   (c_ctx)
    );

    cds_scale #(.FRAC_BITS(FRAC_BITS)) u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c_valid),
        .cos_i     (cos_v),
        .sin_i     (sin_v),
        .ctx_in    (c_ctx),
        .out_valid (m_tvalid),
        .disk_x    (disk_x),
        .disk_y    (disk_y)
    );

    assign m_tdata = {4'b0000, disk_y, disk_x};

endmodule

>>> rtl/core/cds_checker.sv
// port-level checks for the concentric disk sampler, bound to the top level
// depends on concentric_disk_sampler ports only
module cds_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    logic signed [17:0] cx, cy;
    assign cx = m_tdata[17:0];
    assign cy = m_tdata[35:18];

    // a stalled result transfer holds its data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // input side moves exactly when the output slot frees
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output slot");

    // results stay on the closed unit disk box, with zero pad bits
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cx >= -18'sd65536 && cx <= 18'sd65536
                  && cy >= -18'sd65536 && cy <= 18'sd65536
                  && m_tdata[39:36] == 4'b0000)
        else $error("result out of range");

endmodule

bind concentric_disk_sampler cds_checker u_cds_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb_concentric_disk_sampler.sv
// testbench for concentric_disk_sampler: directed table then random sample pairs
// depends on cds_pkg and the rtl top; predicts each point with a fixed-point cordic model
`timescale 1ns / 100ps

module tb_concentric_disk_sampler;

    localparam int FRAC  = 16;
    localparam int STEPS = 16;
    localparam int LAT   = FRAC + STEPS + 5;

    typedef struct packed {
        logic signed [cds_pkg::OUT_W-1:0] dx;
        logic signed [cds_pkg::OUT_W-1:0] dy;
    } point_t;

    typedef struct {
        logic [15:0] ux;
        logic [15:0] uy;
        logic        known;
        point_t      pt;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // u_x, u_y
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // disk_x, disk_y, pad

    point_t pending_points[$];
    int     errors;
    int     idle_tail;

    concentric_disk_sampler #(.FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) i_dut (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic longint rnd_div(input longint n, input longint d);
        longint m;
        longint q;
        m = n < 0 ? -n : n;
        q = (2 * m + d) / (2 * d);
        return n < 0 ? -q : q;
    endfunction

    function automatic longint fshift(input longint v, input int s);
        return v >>> s;   // arithmetic shift is a floor shift
    endfunction

    function automatic logic signed [17:0] scale_clip(input longint r, input longint t);
        longint v;
        v = rnd_div(r * t, longint'(1) << (FRAC - 1));
        if (v > 65536)
            v = 65536;
        if (v < -65536)
            v = -65536;
        return v[17:0];
    endfunction

    function automatic point_t disk_point(input logic [15:0] ux, input logic [15:0] uy);
        longint a, b, ma, mb, major, minor, x, y, z, num, den, dx, dy, t;
        logic   on_x;
        point_t p;
        a = longint'(ux) - 32768;
        b = longint'(uy) - 32768;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = '0;
        if (a == 0 && b == 0)
            return p;
        on_x = ma > mb;
        major = on_x ? a : b;
        minor = on_x ? b : a;
        num = cds_pkg::Q30_PI4 * minor;
        den = major * (longint'(1) << (30 - FRAC));
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        z = rnd_div(num, den);
        x = rnd_div(cds_pkg::Q30_GAIN, longint'(1) << (30 - FRAC));
        y = 0;
        for (int i = 0; i < STEPS && i < 30; i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            t = rnd_div(cds_pkg::ATAN_Q30[i], longint'(1) << (30 - FRAC));
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= t;
            end
            else
            begin
                x += dx;
                y -= dy;
                z += t;
            end
        end
        p.dx = scale_clip(major, on_x ? x : y);
        p.dy = scale_clip(major, on_x ? y : x);
        return p;
    endfunction

    task automatic send_pair(input logic [15:0] ux, input logic [15:0] uy,
                             input logic known, input point_t pt);
        int gap;
        if (!idle_tail && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {uy, ux};
        pending_points.push_back(known ? pt : disk_point(ux, uy));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // output side: random stall bursts, check every transfer
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!idle_tail && $urandom_range(0, 4) == 0)
                    stall = $urandom_range(1, 3);
            end
        end
    end

    always @(posedge clk)
    begin
        point_t want;
        point_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.dx = m_tdata[17:0];
            got.dy = m_tdata[35:18];
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected point x=%0d y=%0d", $time, got.dx, got.dy);
                errors++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (got.dx !== want.dx)
                begin
                    $display("%0t: disk_x expected %0d actual %0d", $time, want.dx, got.dx);
                    errors++;
                end
                if (got.dy !== want.dy)
                begin
                    $display("%0t: disk_y expected %0d actual %0d", $time, want.dy, got.dy);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        row_t   rows[$];
        point_t o;
        logic [15:0] rx;
        logic [15:0] ry;
        int     wait_cnt;
        errors    = 0;
        idle_tail = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        o = '0;
        // origin, axis extremes, corners, equal magnitudes, near-origin steps and mixed values
        rows = '{
            '{16'h8000, 16'h8000, 1'b1, o},
            '{16'h0000, 16'h8000, 1'b0, o},
            '{16'h8000, 16'h0000, 1'b0, o},
            '{16'hFFFF, 16'h8000, 1'b0, o},
            '{16'h8000, 16'hFFFF, 1'b0, o},
            '{16'h0000, 16'h0000, 1'b0, o},
            '{16'hFFFF, 16'hFFFF, 1'b0, o},
            '{16'h0000, 16'hFFFF, 1'b0, o},
            '{16'hFFFF, 16'h0000, 1'b0, o},
            '{16'hC000, 16'hC000, 1'b0, o},
            '{16'h4000, 16'hC000, 1'b0, o},
            '{16'h8001, 16'h8000, 1'b0, o},
            '{16'h7FFF, 16'h8000, 1'b0, o},
            '{16'h8000, 16'h7FFF, 1'b0, o},
            '{16'h8001, 16'h7FFF, 1'b0, o},
            '{16'hFFFF, 16'h0001, 1'b0, o},
            '{16'h1234, 16'hFEDC, 1'b0, o},
            '{16'hAAAA, 16'h5555, 1'b0, o},
            '{16'h5555, 16'hAAAA, 1'b0, o}
        };
        foreach (rows[i])
            send_pair(rows[i].ux, rows[i].uy, rows[i].known, rows[i].pt);

        for (int n = 0; n < 500; n++)
        begin
            if (n == 420)
                idle_tail = 1;
            rx = $urandom();
            ry = $urandom();
            case ($urandom_range(0, 5))
                0: ry = rx;                                  // diagonal
                1: ry = 16'(32'h10000 - rx);                 // anti-diagonal
                2: rx = 16'h8000 + 16'($urandom_range(0, 7)) - 16'd4;
                default: ;
            endcase
            send_pair(rx, ry, 1'b0, o);
        end
        s_tvalid <= 1'b0;

        wait_cnt = 0;
        while (pending_points.size() != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (LAT + 10) @(posedge clk);
        if (errors == 0 && pending_points.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
